>>> design/pidc_pkg.sv
// Shared constants and types for the clamped PID controller.
`default_nettype none

package pidc_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int FRAC_BITS    = 12;
    localparam int GAIN_BITS    = 16;
    localparam int GAIN_FRAC    = 8;
    localparam int TIME_FRAC    = 16;
    localparam int ELAPSED_BITS = 16;
    localparam int DRIVE_BITS   = 14;
    localparam int KIND_BITS    = 2;

    localparam int ERR_BITS     = SAMPLE_BITS + 1;
    localparam int MAG_BITS     = ERR_BITS + 1;
    localparam int DVD_BITS     = MAG_BITS + TIME_FRAC;
    localparam int DIV_CNT_BITS = $clog2(DVD_BITS);
    localparam int MUL_BITS     = GAIN_BITS;
    localparam int MUL_CNT_BITS = $clog2(MUL_BITS);
    localparam int ONE_SHIFT    = FRAC_BITS + GAIN_FRAC;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = GAIN_BITS;

    localparam logic signed [DRIVE_BITS-1:0] DRIVE_POS  = DRIVE_BITS'(1 << FRAC_BITS);
    localparam logic signed [DRIVE_BITS-1:0] DRIVE_NEG  = -DRIVE_POS;
    localparam logic signed [DRIVE_BITS-1:0] DRIVE_ZERO = '0;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_MEAS = 2'd0,
        KIND_SET  = 2'd1,
        KIND_TICK = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GAIN_PROP  = 2'd0,
        CFG_GAIN_DERIV = 2'd1,
        CFG_GAIN_INTEG = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_INT_MUL,
        ST_P_MUL,
        ST_I_MUL,
        ST_D_WAIT,
        ST_D_MUL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic clear;
        logic mp_signed;
    } t_mul_ctl;

endpackage

`default_nettype wire

>>> design/pidc_if.sv
// Valid/ready channel interfaces for controller events and drive results.
`default_nettype none

interface pidc_in_if;
    import pidc_pkg::*;

    logic                           valid;
    logic                           ready;
    logic [KIND_BITS-1:0]           kind;
    logic signed [SAMPLE_BITS-1:0]  sample_value;
    logic [ELAPSED_BITS-1:0]        elapsed;

    modport source (output valid, kind, sample_value, elapsed, input ready);
    modport sink   (input valid, kind, sample_value, elapsed, output ready);
endinterface

interface pidc_out_if;
    import pidc_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [DRIVE_BITS-1:0]   drive;

    modport source (output valid, drive, input ready);
    modport sink   (input valid, drive, output ready);
endinterface

`default_nettype wire

>>> design/pidc_mul.sv
// Bit-serial shift-and-add multiply-accumulate, one multiplier bit per cycle.
`default_nettype none

module pidc_mul #(
    parameter int TERM_W = 32,
    parameter int SUM_W  = 50
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire pidc_pkg::t_mul_ctl        i_ctl,
    input  wire logic signed [TERM_W-1:0]  i_mcand,
    input  wire [pidc_pkg::MUL_BITS-1:0]   i_mplier,
    output logic signed [SUM_W-1:0]        o_acc,
    output logic                           o_done
);
    import pidc_pkg::*;

    localparam logic [MUL_CNT_BITS-1:0] LAST = MUL_CNT_BITS'(MUL_BITS - 1);

    logic                      r_busy;
    logic                      r_done;
    logic                      r_sgn;
    logic [MUL_CNT_BITS-1:0]   r_cnt;
    logic signed [SUM_W-1:0]   r_mc;
    logic [MUL_BITS-1:0]       r_mp;
    logic signed [SUM_W-1:0]   r_acc;

    logic signed [SUM_W-1:0]   addend;
    logic signed [SUM_W-1:0]   n_acc;

    always_comb begin
        addend = r_mp[0] ? r_mc : '0;
        // top bit of a signed multiplier carries negative weight
        if (r_sgn && (r_cnt == LAST)) begin
            n_acc = r_acc - addend;
        end else begin
            n_acc = r_acc + addend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == LAST)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_cnt <= '0;
            r_mc  <= SUM_W'(i_mcand);
            r_mp  <= i_mplier;
            r_sgn <= i_ctl.mp_signed;
            if (i_ctl.clear) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_mc  <= r_mc <<< 1;
            r_mp  <= r_mp >> 1;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

`default_nettype wire

>>> design/pidc_div.sv
// Restoring bit-serial divider for the derivative, one quotient bit per cycle.
`default_nettype none

module pidc_div (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_start,
    input  wire [pidc_pkg::MAG_BITS-1:0]        i_mag,
    input  wire [pidc_pkg::ELAPSED_BITS-1:0]    i_divisor,
    output logic [pidc_pkg::DVD_BITS-1:0]       o_quo,
    output logic                                o_done
);
    import pidc_pkg::*;

    localparam logic [DIV_CNT_BITS-1:0] LAST = DIV_CNT_BITS'(DVD_BITS - 1);

    logic                       r_busy;
    logic                       r_done;
    logic [DIV_CNT_BITS-1:0]    r_cnt;
    logic [DVD_BITS-1:0]        r_dvd;
    logic [ELAPSED_BITS-1:0]    r_rem;
    logic [ELAPSED_BITS-1:0]    r_dsr;

    logic [ELAPSED_BITS:0]      trial;
    logic [ELAPSED_BITS:0]      trial_sub;
    logic                       ge;
    logic [ELAPSED_BITS-1:0]    n_rem;

    always_comb begin
        trial     = {r_rem, r_dvd[DVD_BITS-1]};
        trial_sub = trial - {1'b0, r_dsr};
        ge        = (trial >= {1'b0, r_dsr});
        // remainder stays below the divisor, so the low bits hold it
        n_rem     = ge ? trial_sub[ELAPSED_BITS-1:0] : trial[ELAPSED_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == LAST)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_dvd <= {i_mag, {TIME_FRAC{1'b0}}};
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            // shift the quotient bit in where the dividend bit left
            r_dvd <= {r_dvd[DVD_BITS-2:0], ge};
            r_rem <= n_rem;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_quo  = r_dvd;
    assign o_done = r_done;

endmodule

`default_nettype wire

>>> design/pid_controller_clamped_core.sv
// Clamped PID controller: top level with event handling and tick sequencer.
//
// Usage: events enter on i_req (valid/ready). kind 0 stores a measurement,
// kind 1 a setpoint; neither gives a result. kind 2 is a control tick
// carrying the elapsed time. Once a measurement has been seen, a tick
// yields one drive value on o_rsp (valid/ready), Q1.12 clamped to plus or
// minus 1.0. A tick with zero elapsed time yields 0.
// Gains are written through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
//
// Sequence: a tick with nonzero elapsed time runs four bit-serial products
// (16 shift-add steps each) on one shared multiplier: error*dt, then the
// three gain terms. The 34-step divider for the derivative is done before
// the last. A zero-elapsed tick goes straight from idle to the output step.
// One tick is in flight at a time; i_req.ready is high only while no tick is
// in progress.
//
// Reset clears gains, held values, the integral and the previous error.
// o_rsp has a one-entry output register; a stalled receiver holds the drive
// there, events keep being taken, and a finishing tick waits for the slot.
`default_nettype none

module pid_controller_clamped_core #(
    parameter int ACC_BITS = 32
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire [pidc_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  wire [pidc_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    pidc_in_if.sink                              i_req,
    pidc_out_if.source                           o_rsp
);
    import pidc_pkg::*;

    localparam int TERM_W = (ACC_BITS > ERR_BITS) ? ACC_BITS : ERR_BITS;
    localparam int SUM_W  = TERM_W + GAIN_BITS + 2;
    localparam int IW     = SUM_W - TIME_FRAC;
    localparam int RW     = (DVD_BITS + 1 > ACC_BITS) ? DVD_BITS + 1 : ACC_BITS;

    localparam logic signed [IW-1:0] INT_HI =
        {{(IW - ACC_BITS + 1){1'b0}}, {(ACC_BITS - 1){1'b1}}};
    localparam logic signed [IW-1:0] INT_LO = ~INT_HI;
    localparam logic signed [RW-1:0] RATE_HI =
        {{(RW - ACC_BITS + 1){1'b0}}, {(ACC_BITS - 1){1'b1}}};
    localparam logic signed [RW-1:0] RATE_LO = ~RATE_HI;
    localparam logic signed [SUM_W-1:0] SUM_ONE     = SUM_W'(1) <<< ONE_SHIFT;
    localparam logic signed [SUM_W-1:0] SUM_NEG_ONE = -SUM_ONE;

    // configuration and held state
    logic signed [GAIN_BITS-1:0]    r_gain_p;
    logic signed [GAIN_BITS-1:0]    r_gain_d;
    logic signed [GAIN_BITS-1:0]    r_gain_i;
    logic signed [SAMPLE_BITS-1:0]  r_measured;
    logic signed [SAMPLE_BITS-1:0]  r_target;
    logic                           r_seen;
    logic signed [ERR_BITS-1:0]     r_prev;
    logic signed [ACC_BITS-1:0]     r_integ;

    // per-tick working registers
    t_state                         r_state;
    t_state                         n_state;
    logic signed [ERR_BITS-1:0]     r_err;
    logic [ELAPSED_BITS-1:0]        r_dt;
    logic                           r_zero;
    logic                           r_neg;
    logic signed [ACC_BITS-1:0]     r_rate;
    logic                           r_rate_ok;

    // output register
    logic                           r_out_valid;
    logic signed [DRIVE_BITS-1:0]   r_drive;

    // datapath nets
    logic                           in_xfer;
    logic                           out_free;
    logic                           tick_go;
    logic signed [ERR_BITS-1:0]     err_now;
    logic signed [MAG_BITS-1:0]     diff;
    logic [MAG_BITS-1:0]            mag;
    logic signed [IW-1:0]           inc_ext;
    logic signed [IW-1:0]           integ_sum;
    logic signed [IW-1:0]           integ_sat;
    logic signed [RW-1:0]           q_ext;
    logic signed [RW-1:0]           rate_raw;
    logic signed [RW-1:0]           rate_sat;
    logic signed [DRIVE_BITS-1:0]   drive_calc;

    // sequencer outputs
    logic                           in_ready;
    logic                           emit;
    logic                           div_start;
    t_mul_ctl                       mul_ctl;
    logic signed [TERM_W-1:0]       mul_mcand;
    logic [MUL_BITS-1:0]            mul_mplier;

    logic signed [SUM_W-1:0]        mul_acc;
    logic                           mul_done;
    logic [DVD_BITS-1:0]            div_quo;
    logic                           div_done;

    pidc_mul #(
        .TERM_W (TERM_W),
        .SUM_W  (SUM_W)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mul_ctl),
        .i_mcand  (mul_mcand),
        .i_mplier (mul_mplier),
        .o_acc    (mul_acc),
        .o_done   (mul_done)
    );

    pidc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_mag     (mag),
        .i_divisor (r_dt),
        .o_quo     (div_quo),
        .o_done    (div_done)
    );

    assign in_xfer  = i_req.valid && in_ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign tick_go  = (i_req.kind == KIND_TICK) && r_seen;

    always_comb begin
        err_now = ERR_BITS'(r_target) - ERR_BITS'(r_measured);
        diff    = MAG_BITS'(r_err) - MAG_BITS'(r_prev);
        mag     = diff[MAG_BITS-1] ? MAG_BITS'(-diff) : MAG_BITS'(diff);
    end

    // integral: add floor(err*dt / 2^16) and saturate
    always_comb begin
        inc_ext   = $signed(mul_acc[SUM_W-1:TIME_FRAC]);
        integ_sum = IW'(r_integ) + inc_ext;
        if (integ_sum > INT_HI) begin
            integ_sat = INT_HI;
        end else if (integ_sum < INT_LO) begin
            integ_sat = INT_LO;
        end else begin
            integ_sat = integ_sum;
        end
    end

    // derivative: apply the sign to the magnitude quotient and saturate
    always_comb begin
        q_ext    = $signed(RW'(div_quo));
        rate_raw = r_neg ? -q_ext : q_ext;
        if (rate_raw > RATE_HI) begin
            rate_sat = RATE_HI;
        end else if (rate_raw < RATE_LO) begin
            rate_sat = RATE_LO;
        end else begin
            rate_sat = rate_raw;
        end
    end

    // clamp the gained sum to plus or minus 1.0, else drop the gain fraction; a zero-elapsed tick gives 0
    always_comb begin
        if (r_zero) begin
            drive_calc = DRIVE_ZERO;
        end else if (mul_acc > SUM_ONE) begin
            drive_calc = DRIVE_POS;
        end else if (mul_acc < SUM_NEG_ONE) begin
            drive_calc = DRIVE_NEG;
        end else begin
            drive_calc = $signed(mul_acc[GAIN_FRAC+DRIVE_BITS-1:GAIN_FRAC]);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && tick_go) begin
                    n_state = (i_req.elapsed == '0) ? ST_EMIT : ST_SETUP;
                end
            end
            ST_SETUP:   n_state = ST_INT_MUL;
            ST_INT_MUL: if (mul_done) n_state = ST_P_MUL;
            ST_P_MUL:   if (mul_done) n_state = ST_I_MUL;
            ST_I_MUL:   if (mul_done) n_state = ST_D_WAIT;
            ST_D_WAIT:  if (r_rate_ok) n_state = ST_D_MUL;
            ST_D_MUL:   if (mul_done) n_state = ST_EMIT;
            ST_EMIT:    if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        in_ready   = 1'b0;
        emit       = 1'b0;
        div_start  = 1'b0;
        mul_ctl    = '0;
        mul_mcand  = TERM_W'(r_err);
        mul_mplier = r_dt;
        unique case (r_state)
            ST_IDLE: in_ready = 1'b1;
            ST_SETUP: begin
                div_start     = 1'b1;
                mul_ctl.start = 1'b1;
                mul_ctl.clear = 1'b1;
            end
            ST_INT_MUL: begin
                mul_mplier = r_gain_p;
                if (mul_done) begin
                    mul_ctl.start     = 1'b1;
                    mul_ctl.clear     = 1'b1;
                    mul_ctl.mp_signed = 1'b1;
                end
            end
            ST_P_MUL: begin
                mul_mcand  = TERM_W'(r_integ);
                mul_mplier = r_gain_i;
                if (mul_done) begin
                    mul_ctl.start     = 1'b1;
                    mul_ctl.mp_signed = 1'b1;
                end
            end
            ST_D_WAIT: begin
                mul_mcand  = TERM_W'(r_rate);
                mul_mplier = r_gain_d;
                if (r_rate_ok) begin
                    mul_ctl.start     = 1'b1;
                    mul_ctl.mp_signed = 1'b1;
                end
            end
            ST_EMIT: emit = out_free;
            ST_I_MUL, ST_D_MUL: begin
            end
            default: begin
            end
        endcase
    end

    assign i_req.ready = in_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= '0;
            r_gain_d <= '0;
            r_gain_i <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAIN_PROP:  r_gain_p <= $signed(i_cfg_data);
                CFG_GAIN_DERIV: r_gain_d <= $signed(i_cfg_data);
                CFG_GAIN_INTEG: r_gain_i <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // held state and control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_measured  <= '0;
            r_target    <= '0;
            r_seen      <= 1'b0;
            r_prev      <= '0;
            r_integ     <= '0;
            r_rate_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                case (i_req.kind)
                    KIND_MEAS: begin
                        r_measured <= i_req.sample_value;
                        r_seen     <= 1'b1;
                    end
                    KIND_SET: r_target <= i_req.sample_value;
                    default: begin
                    end
                endcase
            end
            if (r_state == ST_SETUP) begin
                r_prev    <= r_err;
                r_rate_ok <= 1'b0;
            end
            if ((r_state == ST_INT_MUL) && mul_done) begin
                r_integ <= integ_sat[ACC_BITS-1:0];
            end
            if (div_done) begin
                r_rate_ok <= 1'b1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per-tick payload
    always_ff @(posedge i_clk) begin
        if (in_xfer && tick_go) begin
            r_err  <= err_now;
            r_dt   <= i_req.elapsed;
            r_zero <= (i_req.elapsed == '0);
        end
        if (r_state == ST_SETUP) begin
            r_neg <= diff[MAG_BITS-1];
        end
        if (div_done) begin
            r_rate <= rate_sat[ACC_BITS-1:0];
        end
        if (emit) begin
            r_drive <= drive_calc;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.drive = r_drive;

    // the shared multiplier only finishes while a product is owed
    a_mul_done_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == ST_INT_MUL || r_state == ST_P_MUL ||
                      r_state == ST_I_MUL || r_state == ST_D_MUL))
        else $error("multiplier finished outside a product step");

    // the derivative is ready before its product starts
    a_rate_before_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_D_MUL) |-> r_rate_ok)
        else $error("derivative product started without a quotient");

    // a zero-elapsed tick goes straight to the output step with a zero result
    a_zero_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && tick_go && (i_req.elapsed == '0)) |=>
            (r_state == ST_EMIT && r_zero))
        else $error("zero-elapsed tick did not go to output");

    // a loaded drive never exceeds plus or minus 1.0
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_drive <= DRIVE_POS && r_drive >= DRIVE_NEG))
        else $error("drive outside the clamp range");

endmodule

`default_nettype wire
